### hdl/mvc_pkg.sv
// Package for the motor valve controller: widths, register indexes, alarm and status codes.
package mvc_pkg;

  // Default width of the scan timer count
  localparam int unsigned TimerBitsDef = 16;

  // Configuration port
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CONTACTOR_WAIT = 1'b0,
    CFG_TRAVEL_TIME    = 1'b1
  } cfg_idx_e;

  localparam logic [CfgDataW-1:0] ContactorWaitRst = 16'd100;
  localparam logic [CfgDataW-1:0] TravelTimeRst    = 16'd0;

  // Alarm bit positions
  localparam int unsigned AlmW = 6;
  localparam int unsigned ALM_OPEN_TRAVEL   = 0;
  localparam int unsigned ALM_CLOSE_TRAVEL  = 1;
  localparam int unsigned ALM_LEFT_OPEN     = 2;
  localparam int unsigned ALM_LEFT_CLOSED   = 3;
  localparam int unsigned ALM_OPEN_CONTACT  = 4;
  localparam int unsigned ALM_CLOSE_CONTACT = 5;

  // Command group bit positions
  localparam int unsigned CMD_OPEN  = 0;
  localparam int unsigned CMD_CLOSE = 1;
  localparam int unsigned CMD_STOP  = 2;

  // Travel status codes
  typedef logic signed [2:0] status_t;
  localparam status_t ST_IDLE        = 3'sd0;
  localparam status_t ST_WAIT_OPEN   = 3'sd1;
  localparam status_t ST_TRAVEL_OPEN = 3'sd2;
  localparam status_t ST_END_OPEN    = 3'sd3;
  localparam status_t ST_WAIT_CLOSE  = -3'sd1;
  localparam status_t ST_TRAVEL_CLOSE = -3'sd2;
  localparam status_t ST_END_CLOSE   = -3'sd3;

endpackage

### hdl/motor_valve_controller.sv
// Top level of the motor valve controller: scan register, decision logic and result register.
// A request is captured in the input register; its decision is then registered in the result register.
// One scan request per cycle while the result register is free or being taken; the
// scan decision is one pass of boolean and 16-bit compare logic between the input and result registers.
// Reset (asynchronous, active low): valve state, alarms, timer and flags clear,
// contactor wait is 100 scans and travel time is 0 (travel alarms off).
module motor_valve_controller #(
  parameter int unsigned TIMER_BITS = mvc_pkg::TimerBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [mvc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mvc_pkg::CfgDataW-1:0] cfg_data_i,
  // scan request
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   safety_cmds_i,
  input  logic [2:0]                   production_cmds_i,
  input  logic [2:0]                   local_cmds_i,
  input  logic [2:0]                   manual_cmds_i,
  input  logic [1:0]                   auto_cmds_i,
  input  logic [1:0]                   end_switches_i,
  input  logic [1:0]                   contactor_feedback_i,
  input  logic                         local_mode_i,
  input  logic                         manual_mode_i,
  // scan result
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         open_order_o,
  output logic                         close_order_o,
  output logic                         open_indication_o,
  output logic                         closed_indication_o,
  output logic [mvc_pkg::AlmW-1:0]     alarm_bits_o,
  output logic                         any_alarm_o,
  output logic signed [2:0]            travel_status_o
);
  import mvc_pkg::*;

  localparam int unsigned LoadW = (TIMER_BITS > CfgDataW) ? TIMER_BITS : CfgDataW;
  localparam logic [LoadW-1:0] TimerMax = LoadW'({TIMER_BITS{1'b1}});

  // configuration registers
  logic [CfgDataW-1:0] contactor_wait_q, travel_time_q;

  // input stage
  logic       s1_valid_q;
  logic [2:0] safety_q, production_q, local_q, manual_q;
  logic [1:0] auto_q, end_sw_q, contact_q;
  logic       local_mode_q, manual_mode_q;

  // valve state
  status_t             status_q, status_d;
  logic                open_order_q, open_order_d;
  logic                close_order_q, close_order_d;
  logic [AlmW-1:0]     alarm_q, alarm_d;
  logic                prev_open_q, prev_close_q;
  logic [TIMER_BITS-1:0] timer_cnt_q, timer_cnt_d;
  logic                timer_run_q, timer_run_d;

  // result stage
  logic            out_valid_q;
  logic            res_open_q, res_close_q, res_ind_open_q, res_ind_closed_q;
  logic [AlmW-1:0] res_alarm_q;
  status_t         res_status_q;

  // decode helpers
  logic s_open, s_close, s_stop, p_open, p_close, p_stop;
  logic l_open, l_close, l_stop, m_open, m_close, m_stop;
  logic a_open, a_close, e_open, e_close, c_open, c_close;
  logic oreq, creq, op, cl, ind_open, ind_closed;
  logic [TIMER_BITS-1:0] cnt_tick, wait_load, travel_load;
  logic run_tick;
  logic [LoadW-1:0] wait_ext, travel_ext;

  logic accept, advance;

  // handshake: the scan stage moves on whenever the result register is free or being taken
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contactor_wait_q <= ContactorWaitRst;
      travel_time_q    <= TravelTimeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CONTACTOR_WAIT: contactor_wait_q <= cfg_data_i;
        CFG_TRAVEL_TIME:    travel_time_q    <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      safety_q      <= safety_cmds_i;
      production_q  <= production_cmds_i;
      local_q       <= local_cmds_i;
      manual_q      <= manual_cmds_i;
      auto_q        <= auto_cmds_i;
      end_sw_q      <= end_switches_i;
      contact_q     <= contactor_feedback_i;
      local_mode_q  <= local_mode_i;
      manual_mode_q <= manual_mode_i;
    end
  end

  // command decode
  assign s_open  = safety_q[CMD_OPEN];
  assign s_close = safety_q[CMD_CLOSE];
  assign s_stop  = safety_q[CMD_STOP];
  assign p_open  = production_q[CMD_OPEN];
  assign p_close = production_q[CMD_CLOSE];
  assign p_stop  = production_q[CMD_STOP];
  assign l_open  = local_q[CMD_OPEN];
  assign l_close = local_q[CMD_CLOSE];
  assign l_stop  = local_q[CMD_STOP];
  assign m_open  = manual_q[CMD_OPEN];
  assign m_close = manual_q[CMD_CLOSE];
  assign m_stop  = manual_q[CMD_STOP];
  assign a_open  = auto_q[0];
  assign a_close = auto_q[1];
  assign e_open  = end_sw_q[0];
  assign e_close = end_sw_q[1];
  assign c_open  = contact_q[0];
  assign c_close = contact_q[1];
  assign oreq    = a_open || p_open || s_open;
  assign creq    = a_close || p_close || s_close;

  // timer load values, saturated to the count width
  assign wait_ext    = LoadW'(contactor_wait_q);
  assign travel_ext  = LoadW'(travel_time_q);
  assign wait_load   = TIMER_BITS'((wait_ext > TimerMax) ? TimerMax : wait_ext);
  assign travel_load = TIMER_BITS'((travel_ext > TimerMax) ? TimerMax : travel_ext);

  // timer count-down at the start of the scan
  assign cnt_tick = (timer_run_q && (timer_cnt_q != '0)) ? timer_cnt_q - 1'b1 : timer_cnt_q;
  assign run_tick = timer_run_q && (cnt_tick != '0);

  // scan decision
  always_comb begin
    alarm_d     = alarm_q;
    status_d    = status_q;
    timer_cnt_d = cnt_tick;
    timer_run_d = run_tick;
    op          = 1'b0;
    cl          = 1'b0;

    // alarm removal
    if ((oreq && !prev_open_q) || m_open || m_stop) alarm_d[ALM_OPEN_CONTACT] = 1'b0;
    if ((creq && !prev_close_q) || m_close || m_stop) alarm_d[ALM_CLOSE_CONTACT] = 1'b0;
    if (e_open) begin
      alarm_d[ALM_OPEN_TRAVEL] = 1'b0;
      if (!e_close) alarm_d[ALM_LEFT_OPEN] = 1'b0;
    end
    if (e_close) begin
      alarm_d[ALM_CLOSE_TRAVEL] = 1'b0;
      if (!e_open) alarm_d[ALM_LEFT_CLOSED] = 1'b0;
    end
    if (close_order_q) begin
      alarm_d[ALM_OPEN_TRAVEL]  = 1'b0;
      alarm_d[ALM_LEFT_OPEN]    = 1'b0;
      alarm_d[ALM_OPEN_CONTACT] = 1'b0;
    end
    if (open_order_q) begin
      alarm_d[ALM_CLOSE_TRAVEL]  = 1'b0;
      alarm_d[ALM_LEFT_CLOSED]   = 1'b0;
      alarm_d[ALM_CLOSE_CONTACT] = 1'b0;
    end

    // request selection: safety, local, production, manual, automatic
    priority if (s_stop) begin
      op = 1'b0;
    end else if (s_close) begin
      cl = !alarm_d[ALM_CLOSE_CONTACT];
    end else if (s_open) begin
      op = !alarm_d[ALM_OPEN_CONTACT];
    end else if (local_mode_q) begin
      priority if (l_stop) begin
        op = 1'b0;
      end else if (l_close) begin
        cl = 1'b1;
      end else if (l_open) begin
        op = 1'b1;
      end else if (open_order_q) begin
        op = c_open;
      end else if (close_order_q) begin
        cl = c_close;
      end else begin
        op = 1'b0;
      end
    end else if (p_stop) begin
      op = 1'b0;
    end else if (p_close) begin
      cl = !alarm_d[ALM_CLOSE_CONTACT];
    end else if (p_open) begin
      op = !alarm_d[ALM_OPEN_CONTACT];
    end else if (manual_mode_q) begin
      priority if (m_stop) begin
        op = 1'b0;
      end else if (m_close) begin
        cl = 1'b1;
      end else if (m_open) begin
        op = 1'b1;
      end else if (open_order_q) begin
        op = !alarm_d[ALM_OPEN_CONTACT];
      end else if (close_order_q) begin
        cl = !alarm_d[ALM_CLOSE_CONTACT];
      end else begin
        op = 1'b0;
      end
    end else begin
      priority if (a_close) begin
        cl = !alarm_d[ALM_CLOSE_CONTACT];
      end else if (a_open) begin
        op = !alarm_d[ALM_OPEN_CONTACT];
      end else begin
        op = 1'b0;
      end
    end

    // valve left its end position, or both end switches on
    if ((status_d == ST_END_OPEN) && (!e_open || e_close)) begin
      alarm_d[ALM_LEFT_OPEN] = 1'b1;
      status_d = ST_IDLE;
    end
    if ((status_d == ST_END_CLOSE) && (e_open || !e_close)) begin
      alarm_d[ALM_LEFT_CLOSED] = 1'b1;
      status_d = ST_IDLE;
    end
    if (e_open && e_close) begin
      alarm_d[ALM_LEFT_OPEN]   = 1'b1;
      alarm_d[ALM_LEFT_CLOSED] = 1'b1;
    end

    // new orders; an opposite contactor still on blocks the order
    if (op && !open_order_q) begin
      if (c_close) begin
        status_d = ST_IDLE;
      end else begin
        timer_cnt_d = wait_load;
        timer_run_d = 1'b1;
        status_d    = ST_WAIT_OPEN;
      end
    end
    if (cl && !close_order_q) begin
      if (c_open) begin
        status_d = ST_IDLE;
      end else begin
        timer_cnt_d = wait_load;
        timer_run_d = 1'b1;
        status_d    = ST_WAIT_CLOSE;
      end
    end
    if (!op && !cl && (status_d > ST_END_CLOSE) && (status_d < ST_END_OPEN)) begin
      status_d = ST_IDLE;
    end

    open_order_d  = (e_open || cl || (status_d <= ST_IDLE)) ? 1'b0 : op;
    close_order_d = (e_close || (status_d >= ST_IDLE)) ? 1'b0 : cl;

    ind_open   = e_open && !e_close && !cl && !local_mode_q;
    ind_closed = !e_open && e_close && !op && !local_mode_q;

    // contactor and travel supervision
    if (open_order_d) begin
      if (!c_open && ((status_d > ST_WAIT_OPEN) || !timer_run_d)) begin
        alarm_d[ALM_OPEN_CONTACT] = 1'b1;
      end
      if ((status_d == ST_WAIT_OPEN) && c_open && !timer_run_d) begin
        timer_cnt_d = travel_load;
        timer_run_d = 1'b1;
        status_d    = ST_TRAVEL_OPEN;
      end
      if ((status_d == ST_TRAVEL_OPEN) && !timer_run_d && (travel_time_q != '0)) begin
        alarm_d[ALM_OPEN_TRAVEL] = 1'b1;
      end
    end else if (close_order_d) begin
      if (!c_close && ((status_d < ST_WAIT_CLOSE) || !timer_run_d)) begin
        alarm_d[ALM_CLOSE_CONTACT] = 1'b1;
      end
      if ((status_d == ST_WAIT_CLOSE) && c_close && !timer_run_d) begin
        timer_cnt_d = travel_load;
        timer_run_d = 1'b1;
        status_d    = ST_TRAVEL_CLOSE;
      end
      if ((status_d == ST_TRAVEL_CLOSE) && !timer_run_d && (travel_time_q != '0)) begin
        alarm_d[ALM_CLOSE_TRAVEL] = 1'b1;
      end
    end

    // end position reached
    if (e_open && op) status_d = ST_END_OPEN;
    if (e_close && cl) status_d = ST_END_CLOSE;
  end

  // valve state, updated once per scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q      <= ST_IDLE;
      open_order_q  <= 1'b0;
      close_order_q <= 1'b0;
      alarm_q       <= '0;
      prev_open_q   <= 1'b0;
      prev_close_q  <= 1'b0;
      timer_cnt_q   <= '0;
      timer_run_q   <= 1'b0;
    end else if (advance) begin
      status_q      <= status_d;
      open_order_q  <= open_order_d;
      close_order_q <= close_order_d;
      alarm_q       <= alarm_d;
      prev_open_q   <= oreq;
      prev_close_q  <= creq;
      timer_cnt_q   <= timer_cnt_d;
      timer_run_q   <= timer_run_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_open_q       <= open_order_d;
      res_close_q      <= close_order_d;
      res_ind_open_q   <= ind_open;
      res_ind_closed_q <= ind_closed;
      res_alarm_q      <= alarm_d;
      res_status_q     <= status_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign open_order_o        = res_open_q;
  assign close_order_o       = res_close_q;
  assign open_indication_o   = res_ind_open_q;
  assign closed_indication_o = res_ind_closed_q;
  assign alarm_bits_o        = res_alarm_q;
  assign any_alarm_o         = |res_alarm_q;
  assign travel_status_o     = res_status_q;

endmodule

### hdl/mvc_checker.sv
// Port-level checker for the motor valve controller, bound to the top level.
module mvc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         open_order_o,
  input logic                         close_order_o,
  input logic                         open_indication_o,
  input logic                         closed_indication_o,
  input logic [mvc_pkg::AlmW-1:0]     alarm_bits_o,
  input logic                         any_alarm_o,
  input logic signed [2:0]            travel_status_o
);
  import mvc_pkg::*;

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // the motor is never driven both ways, nor shown at both end positions
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(open_order_o && close_order_o)
                    && !(open_indication_o && closed_indication_o))
    else $error("conflicting orders or indications");

  // summary alarm follows the alarm bits
  a_any_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (any_alarm_o == (alarm_bits_o != '0)))
    else $error("summary alarm mismatch");

  // an open order only while waiting for the contactor or travelling open
  a_open_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && open_order_o |->
      (travel_status_o == ST_WAIT_OPEN) || (travel_status_o == ST_TRAVEL_OPEN))
    else $error("open order with wrong travel status");

  // a close order only while waiting for the contactor or travelling closed
  a_close_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && close_order_o |->
      (travel_status_o == ST_WAIT_CLOSE) || (travel_status_o == ST_TRAVEL_CLOSE))
    else $error("close order with wrong travel status");

endmodule

bind motor_valve_controller mvc_checker u_mvc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .open_order_o        (open_order_o),
  .close_order_o       (close_order_o),
  .open_indication_o   (open_indication_o),
  .closed_indication_o (closed_indication_o),
  .alarm_bits_o        (alarm_bits_o),
  .any_alarm_o         (any_alarm_o),
  .travel_status_o     (travel_status_o)
);
